/* rtl/spq_pkg.sv */
`default_nettype none

package spq_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int COUNT_BITS = 5;
   localparam int QUEUE_DEPTH = 2;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_READ_OUT = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic signed [31:0] item_value;
      logic signed [31:0] item_priority;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0]    out_value;
      logic signed [31:0]    out_priority;
      logic                  entry_valid;
      logic                  last_result;
      logic [COUNT_BITS-1:0] entry_count;
      logic                  overflow;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type req;
   } queue_head_type;

endpackage

`default_nettype wire

/* rtl/spq_front.sv */
`default_nettype none

module spq_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   output logic                  full,
   input  spq_pkg::req_item_type req_data,
   output spq_pkg::queue_head_type head,
   input  wire                   deq
);
   import spq_pkg::*;

   localparam int PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LevelBits = $clog2(QUEUE_DEPTH + 1);

   req_item_type         slots_ff [QUEUE_DEPTH];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LevelBits-1:0] level_ff, level_in;
   logic                 do_write, do_read;

   assign full = (level_ff == LevelBits'(QUEUE_DEPTH));
   assign do_write = push && !full;
   assign do_read = deq && (level_ff != '0);

   assign head.valid = (level_ff != '0);
   assign head.req = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in = level_ff;
      if (do_write) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_read) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_write && !do_read) begin
         level_in = level_ff + 1'b1;
      end else if (do_read && !do_write) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         slots_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/spq_back.sv */
`default_nettype none

module spq_back #(
   parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
   input  wire                     clock,
   input  wire                     reset,
   input  spq_pkg::queue_head_type head,
   output logic                    deq,
   output logic                    out_valid,
   output spq_pkg::rsp_item_type   out_data,
   input  wire                     pop
);
   import spq_pkg::*;

   localparam int CountW = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [CountW-1:0]  count_ff, count_in;
   logic [CountW-1:0]  remaining_ff, remaining_in;
   logic               out_valid_ff, out_valid_in;
   rsp_item_type       out_ff, out_in;
   logic signed [31:0] value_ff [CAPACITY];
   logic signed [31:0] value_in [CAPACITY];
   logic signed [31:0] prio_ff [CAPACITY];
   logic signed [31:0] prio_in [CAPACITY];
   logic [CAPACITY-1:0] take;
   logic               can_emit, do_insert, do_rotate;

   assign can_emit = !out_valid_ff || pop;
   assign out_valid = out_valid_ff;
   assign out_data = out_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      remaining_in = remaining_ff;
      out_valid_in = out_valid_ff && !pop;
      out_in = out_ff;
      deq = 1'b0;
      do_insert = 1'b0;
      do_rotate = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid && can_emit) begin
               deq = 1'b1;
               out_valid_in = 1'b1;
               out_in = '0;
               out_in.last_result = 1'b1;
               if (head.req.req_type == REQ_INSERT) begin
                  do_insert = 1'b1;
                  if (count_ff == CountW'(CAPACITY)) begin
                     out_in.overflow = 1'b1;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
                  out_in.entry_count = COUNT_BITS'(count_in);
               end else if (count_ff != '0) begin
                  do_rotate = 1'b1;
                  out_in.out_value = value_ff[0];
                  out_in.out_priority = prio_ff[0];
                  out_in.entry_valid = 1'b1;
                  out_in.last_result = (count_ff == CountW'(1));
                  out_in.entry_count = COUNT_BITS'(count_ff);
                  remaining_in = count_ff - 1'b1;
                  if (count_ff != CountW'(1)) begin
                     state_in = ST_READ;
                  end
               end
            end
         end
         ST_READ: begin
            if (can_emit) begin
               do_rotate = 1'b1;
               out_valid_in = 1'b1;
               out_in.out_value = value_ff[0];
               out_in.out_priority = prio_ff[0];
               out_in.entry_valid = 1'b1;
               out_in.last_result = (remaining_ff == CountW'(1));
               out_in.entry_count = COUNT_BITS'(count_ff);
               out_in.overflow = 1'b0;
               remaining_in = remaining_ff - 1'b1;
               if (remaining_ff == CountW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign take[i] = (CountW'(i) >= count_ff) || (head.req.item_priority >= prio_ff[i]);

      always_comb begin
         value_in[i] = value_ff[i];
         prio_in[i] = prio_ff[i];
         if (do_insert && take[i]) begin
            if (i == 0) begin
               value_in[i] = head.req.item_value;
               prio_in[i] = head.req.item_priority;
            end else if (!take[(i == 0) ? 0 : i - 1]) begin
               value_in[i] = head.req.item_value;
               prio_in[i] = head.req.item_priority;
            end else begin
               value_in[i] = value_ff[(i == 0) ? 0 : i - 1];
               prio_in[i] = prio_ff[(i == 0) ? 0 : i - 1];
            end
         end else if (do_rotate && (CountW'(i) < count_ff)) begin
            if ((i == CAPACITY - 1) || (CountW'(i + 1) == count_ff)) begin
               value_in[i] = value_ff[0];
               prio_in[i] = prio_ff[0];
            end else begin
               value_in[i] = value_ff[(i == CAPACITY - 1) ? i : i + 1];
               prio_in[i] = prio_ff[(i == CAPACITY - 1) ? i : i + 1];
            end
         end
      end

      always_ff @(posedge clock) begin
         value_ff[i] <= value_in[i];
         prio_ff[i] <= prio_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         remaining_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         remaining_ff <= remaining_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

`default_nettype wire

/* rtl/sorted_insert_priority_queue.sv */
// Sorted-insert priority queue holding up to CAPACITY (value, priority) entries,
// kept in order from highest to lowest priority, with ties placed newest first.
// Requests enter through a queue interface: a transfer happens when push is high
// and full is low. Results leave through a second queue interface: the oldest
// result is shown while empty is low and is transferred when pop is high.
// An insert yields one acknowledgement with the new count and an overflow flag;
// on a full store the lowest entry is dropped. A read-out yields every stored
// entry in priority order, the last one marked, or a single invalid result when
// the store is empty.
// Each result is held in the output register. Inserts are taken one per cycle
// while the output register can take a result, since every cell compares and
// shifts in parallel; a read-out yields the stored entries in turn as the cell
// array rotates through its head cell. A two-entry request queue lets requests
// be taken while the back end works or a result waits in the output register.
// When the receiver stalls, the output register holds its result, the back end
// waits, and full rises once the request queue is filled.
// Reset empties the store and both queues; no request or result is pending.

`default_nettype none

module sorted_insert_priority_queue #(
   parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   output logic                  full,
   input  spq_pkg::req_item_type req_data,
   output logic                  empty,
   input  wire                   pop,
   output spq_pkg::rsp_item_type rsp_data
);
   import spq_pkg::*;

   queue_head_type head;
   logic           deq;
   logic           out_valid;

   spq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .head     (head),
      .deq      (deq)
   );

   spq_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .deq       (deq),
      .out_valid (out_valid),
      .out_data  (rsp_data),
      .pop       (pop)
   );

   assign empty = !out_valid;

endmodule

`default_nettype wire

/* rtl/spq_checker.sv */
`default_nettype none

module spq_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   empty,
   input wire                   pop,
   input spq_pkg::rsp_item_type rsp_data
);
   import spq_pkg::*;

   a_reset_empty : assert property (@(posedge clock) reset |=> empty)
      else $error("Result channel not empty after reset.");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("Stalled result changed or vanished.");

   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.entry_valid) |->
         (rsp_data.out_value == 0 && rsp_data.out_priority == 0 && rsp_data.last_result))
      else $error("Result without an entry carries data or is not the last.");

   a_overflow_ack : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.overflow) |-> !rsp_data.entry_valid)
      else $error("Overflow flagged on a read-out result.");

endmodule

bind sorted_insert_priority_queue spq_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);

`default_nettype wire
